// ===== sv/rabin_pkg.sv =====
// Package: widths, register map, payload structs and sequencer states of the Rabin engine.
package rabin_pkg;

  localparam int PRIME_BITS = 16;
  localparam int COEF_BITS  = PRIME_BITS + 2;
  localparam int EXP_BITS   = PRIME_BITS - 1;
  localparam int WORD_BITS  = 32;
  localparam int ADDR_BITS  = 4;
  localparam int CNT_BITS   = 6;

  localparam logic [PRIME_BITS-1:0] PRIME_P_RST = PRIME_BITS'(3);
  localparam logic [PRIME_BITS-1:0] PRIME_Q_RST = PRIME_BITS'(7);
  localparam logic [WORD_BITS-1:0]  MODULUS_RST = WORD_BITS'(21);

  typedef enum logic [1:0] {
    REG_PRIME_P = 2'd0,
    REG_PRIME_Q = 2'd1,
    REG_MODULUS = 2'd2
  } reg_idx_e;

  typedef enum logic {
    ACT_ENCRYPT = 1'b0,
    ACT_DECRYPT = 1'b1
  } action_e;

  typedef struct packed {
    logic                 action;
    logic [WORD_BITS-1:0] value;
  } in_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] root_one;
    logic [WORD_BITS-1:0] root_two;
    logic [WORD_BITS-1:0] root_three;
    logic [WORD_BITS-1:0] root_four;
  } out_t;

  typedef enum logic [23:0] {
    S_IDLE      = 24'h000001,
    S_RUN       = 24'h000002,
    S_ENC_SQ    = 24'h000004,
    S_ENC_FIN   = 24'h000008,
    S_POW_START = 24'h000010,
    S_POW_BASE  = 24'h000020,
    S_POW_LOOP  = 24'h000040,
    S_POW_MULD  = 24'h000080,
    S_POW_SQ    = 24'h000100,
    S_POW_SQD   = 24'h000200,
    S_POW_DONE  = 24'h000400,
    S_EUC_START = 24'h000800,
    S_EUC_LOOP  = 24'h001000,
    S_EUC_UPX   = 24'h002000,
    S_EUC_UPY   = 24'h004000,
    S_RED_CQ    = 24'h008000,
    S_RED_CQD   = 24'h010000,
    S_TQ2       = 24'h020000,
    S_RED_CP    = 24'h040000,
    S_RED_CPD   = 24'h080000,
    S_TP2       = 24'h100000,
    S_FIN       = 24'h200000,
    S_FIN2      = 24'h400000,
    S_EMIT      = 24'h800000
  } state_e;

endpackage

// ===== sv/rabin_encrypt_decrypt.sv =====
// Rabin encrypt / decrypt engine: APB key registers, sequencer and shared modular multiplier.
//
// Usage: program prime_p (0x0), prime_q (0x4) and modulus n (0x8) over the APB
// port while the engine is idle, then send beats on the input channel (action,
// value). Each input beat yields exactly one output beat with four roots.
// Encrypt gives value^2 mod n in root_one and zeros elsewhere. Decrypt runs two
// modular exponentiations (mod p and mod q), an extended Euclid on p and q,
// and a CRT combination into x, n-x, y, n-y.
// All arithmetic runs through one shift-and-add modular multiplier that steps through
// 32 multiplier bits per product; division for Euclid uses the same unit with a unit
// multiplicand and collects quotient bits.
// The input channel stalls for the whole item (one item at a time).
// The result sits in an output register; a new input beat is taken while it
// waits, and a finished result waits in a holding register if the receiver
// still stalls the previous one. A zero modulus gives an all-zero result.
// Reset returns the key registers to p=3, q=7, n=21 and empties the pipeline.
module rabin_encrypt_decrypt
  import rabin_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [WORD_BITS-1:0] pwdata,
  output logic [WORD_BITS-1:0] prdata,
  output logic                 pready,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_data_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o
);

  // key registers
  logic [PRIME_BITS-1:0] prime_p_q, prime_q_q;
  logic [WORD_BITS-1:0]  modulus_q;

  // sequencer
  state_e state_q, nxt_q, go_nxt;
  logic   act_q, sel_q;
  logic [WORD_BITS-1:0] value_q;

  // exponentiation
  logic [PRIME_BITS-1:0] pm_q, pm_sel;
  logic [PRIME_BITS:0]   pm_inc;
  logic [EXP_BITS-1:0]   exp_q;
  logic [WORD_BITS-1:0]  base_q, pacc_q, r_q, s_q;

  // extended Euclid
  logic [PRIME_BITS-1:0]       ea_q, eb_q;
  logic signed [COEF_BITS-1:0] xa_q, ya_q, xb_q, yb_q, xtmp_q;
  logic signed [COEF_BITS-1:0] mul_in, sub_in, coef_new;
  logic signed [PRIME_BITS+COEF_BITS:0] prod;

  // combination
  logic [WORD_BITS-1:0] tq_q, x_q, y_q;
  logic [WORD_BITS:0]   sx, sy, n33;
  logic [WORD_BITS-1:0] x_d, y_d;

  // results
  out_t res_q, out_q;
  logic out_valid_q;
  logic emit_go;

  // shared modular multiplier
  logic                 mu_busy_q;
  logic [CNT_BITS-1:0]  mu_cnt_q;
  logic [WORD_BITS-1:0] mu_acc_q, mu_a_q, mu_b_q, mu_m_q, mu_quo_q;
  logic [WORD_BITS:0]   mu_t1, mu_t1b, mu_t2, mu_m33, mu_r;
  logic                 mu_s1, mu_s2;
  logic                 mu_go;
  logic [WORD_BITS-1:0] mu_a_in, mu_b_in, mu_m_in;

  function automatic logic [WORD_BITS-1:0] coef_mag(logic signed [COEF_BITS-1:0] v);
    logic [COEF_BITS-1:0] m;
    m = v[COEF_BITS-1] ? COEF_BITS'(-v) : COEF_BITS'(v);
    return WORD_BITS'(m);
  endfunction

  // v mod n mapped back for a negative source value
  function automatic logic [WORD_BITS-1:0] fix_neg(logic neg, logic [WORD_BITS-1:0] v,
                                                   logic [WORD_BITS-1:0] n);
    logic [WORD_BITS-1:0] r;
    r = v;
    if (neg && (v != '0)) r = n - v;
    return r;
  endfunction

  function automatic logic [WORD_BITS-1:0] neg_mod(logic [WORD_BITS-1:0] v,
                                                   logic [WORD_BITS-1:0] n);
    return (v == '0) ? '0 : n - v;
  endfunction

  assign pready      = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // result moves to the output register when that is free or draining
  assign emit_go = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  // register read
  always_comb begin
    unique case (paddr[3:2])
      REG_PRIME_P: prdata = WORD_BITS'(prime_p_q);
      REG_PRIME_Q: prdata = WORD_BITS'(prime_q_q);
      REG_MODULUS: prdata = modulus_q;
      default:     prdata = '0;
    endcase
  end

  // multiplier step: acc = 2*acc + abit*b, reduced mod m; quotient bit when b is one
  always_comb begin
    mu_m33 = {1'b0, mu_m_q};
    mu_t1  = {mu_acc_q, 1'b0};
    mu_s1  = (mu_t1 >= mu_m33);
    mu_t1b = mu_s1 ? (mu_t1 - mu_m33) : mu_t1;
    mu_t2  = mu_t1b + (mu_a_q[WORD_BITS-1] ? {1'b0, mu_b_q} : '0);
    mu_s2  = (mu_t2 >= mu_m33);
    mu_r   = mu_s2 ? (mu_t2 - mu_m33) : mu_t2;
  end

  // Euclid coefficient update, one multiplier shared by both rows
  always_comb begin
    mul_in   = (state_q == S_EUC_UPX) ? xa_q : ya_q;
    sub_in   = (state_q == S_EUC_UPX) ? xb_q : yb_q;
    prod     = $signed({1'b0, mu_quo_q[PRIME_BITS-1:0]}) * mul_in;
    coef_new = sub_in - prod[COEF_BITS-1:0];
  end

  // exponent (p+1)/4 of the selected prime
  assign pm_sel = sel_q ? prime_q_q : prime_p_q;
  assign pm_inc = {1'b0, pm_sel} + (PRIME_BITS+1)'(1);

  // CRT sums
  always_comb begin
    n33 = {1'b0, modulus_q};
    sx  = {1'b0, tq_q} + {1'b0, mu_acc_q};
    sy  = {1'b0, tq_q} + (n33 - {1'b0, mu_acc_q});
    x_d = (sx >= n33) ? WORD_BITS'(sx - n33) : sx[WORD_BITS-1:0];
    y_d = (sy >= n33) ? WORD_BITS'(sy - n33) : sy[WORD_BITS-1:0];
  end

  // multiplier launches
  always_comb begin
    mu_go   = 1'b0;
    mu_a_in = value_q;
    mu_b_in = WORD_BITS'(1);
    mu_m_in = modulus_q;
    go_nxt  = S_IDLE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && (modulus_q != '0) && (in_data_i.action == ACT_ENCRYPT)) begin
          mu_go   = 1'b1;
          mu_a_in = in_data_i.value;
          go_nxt  = S_ENC_SQ;
        end
      end
      S_ENC_SQ: begin
        mu_go   = 1'b1;
        mu_a_in = mu_acc_q;
        mu_b_in = mu_acc_q;
        go_nxt  = S_ENC_FIN;
      end
      S_POW_START: begin
        mu_go   = (pm_sel != '0);
        mu_m_in = WORD_BITS'(pm_sel);
        go_nxt  = S_POW_BASE;
      end
      S_POW_LOOP: begin
        mu_go   = (exp_q != '0) && exp_q[0];
        mu_a_in = base_q;
        mu_b_in = pacc_q;
        mu_m_in = WORD_BITS'(pm_q);
        go_nxt  = S_POW_MULD;
      end
      S_POW_SQ: begin
        mu_go   = 1'b1;
        mu_a_in = base_q;
        mu_b_in = base_q;
        mu_m_in = WORD_BITS'(pm_q);
        go_nxt  = S_POW_SQD;
      end
      S_EUC_LOOP: begin
        mu_go   = (ea_q != '0);
        mu_a_in = WORD_BITS'(eb_q);
        mu_m_in = WORD_BITS'(ea_q);
        go_nxt  = S_EUC_UPX;
      end
      S_RED_CQ: begin
        mu_go   = 1'b1;
        mu_a_in = coef_mag(yb_q);
        go_nxt  = S_RED_CQD;
      end
      S_RED_CQD: begin
        mu_go   = 1'b1;
        mu_a_in = r_q;
        mu_b_in = fix_neg(yb_q[COEF_BITS-1], mu_acc_q, modulus_q);
        go_nxt  = S_TQ2;
      end
      S_TQ2: begin
        mu_go   = 1'b1;
        mu_a_in = WORD_BITS'(prime_q_q);
        mu_b_in = mu_acc_q;
        go_nxt  = S_RED_CP;
      end
      S_RED_CP: begin
        mu_go   = 1'b1;
        mu_a_in = coef_mag(xb_q);
        go_nxt  = S_RED_CPD;
      end
      S_RED_CPD: begin
        mu_go   = 1'b1;
        mu_a_in = s_q;
        mu_b_in = fix_neg(xb_q[COEF_BITS-1], mu_acc_q, modulus_q);
        go_nxt  = S_TP2;
      end
      S_TP2: begin
        mu_go   = 1'b1;
        mu_a_in = WORD_BITS'(prime_p_q);
        mu_b_in = mu_acc_q;
        go_nxt  = S_FIN;
      end
      default: begin
        mu_go = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_p_q   <= PRIME_P_RST;
      prime_q_q   <= PRIME_Q_RST;
      modulus_q   <= MODULUS_RST;
      state_q     <= S_IDLE;
      nxt_q       <= S_IDLE;
      out_valid_q <= 1'b0;
      mu_busy_q   <= 1'b0;
      mu_cnt_q    <= '0;
      mu_acc_q    <= '0;
      mu_m_q      <= WORD_BITS'(1);
    end else begin
      // config writes
      if (psel && penable && pwrite && pready) begin
        unique case (paddr[3:2])
          REG_PRIME_P: prime_p_q <= pwdata[PRIME_BITS-1:0];
          REG_PRIME_Q: prime_q_q <= pwdata[PRIME_BITS-1:0];
          REG_MODULUS: modulus_q <= pwdata;
          default:     prime_p_q <= prime_p_q;
        endcase
      end

      if (emit_go) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;

      // shared unit, one multiplier bit per cycle
      if (mu_busy_q) begin
        mu_acc_q <= mu_r[WORD_BITS-1:0];
        mu_a_q   <= {mu_a_q[WORD_BITS-2:0], 1'b0};
        mu_quo_q <= {mu_quo_q[WORD_BITS-2:0], mu_s1 | mu_s2};
        mu_cnt_q <= mu_cnt_q - CNT_BITS'(1);
        if (mu_cnt_q == CNT_BITS'(1)) mu_busy_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            act_q   <= in_data_i.action;
            value_q <= in_data_i.value;
            sel_q   <= 1'b0;
            if (modulus_q == '0) begin
              res_q   <= '0;
              state_q <= S_EMIT;
            end else if (in_data_i.action == ACT_DECRYPT) begin
              state_q <= S_POW_START;
            end
          end
        end
        S_RUN: begin
          if (!mu_busy_q) state_q <= nxt_q;
        end
        S_ENC_FIN: begin
          res_q   <= '{root_one: mu_acc_q, root_two: '0, root_three: '0, root_four: '0};
          state_q <= S_EMIT;
        end
        S_POW_START: begin
          pm_q  <= pm_sel;
          exp_q <= pm_inc[PRIME_BITS:2];
          if (pm_sel == '0) begin
            pacc_q  <= '0;
            state_q <= S_POW_DONE;
          end else begin
            pacc_q  <= WORD_BITS'(1);
          end
        end
        S_POW_BASE: begin
          base_q  <= mu_acc_q;
          state_q <= S_POW_LOOP;
        end
        S_POW_LOOP: begin
          if (exp_q == '0)   state_q <= S_POW_DONE;
          else if (!exp_q[0]) state_q <= S_POW_SQ;
        end
        S_POW_MULD: begin
          pacc_q  <= mu_acc_q;
          state_q <= S_POW_SQ;
        end
        S_POW_SQ: begin
          exp_q <= exp_q >> 1;
        end
        S_POW_SQD: begin
          base_q  <= mu_acc_q;
          state_q <= S_POW_LOOP;
        end
        S_POW_DONE: begin
          if (!sel_q) begin
            r_q     <= pacc_q;
            sel_q   <= 1'b1;
            state_q <= S_POW_START;
          end else begin
            s_q     <= pacc_q;
            state_q <= S_EUC_START;
          end
        end
        S_EUC_START: begin
          ea_q    <= prime_p_q;
          eb_q    <= prime_q_q;
          xa_q    <= COEF_BITS'(1);
          ya_q    <= '0;
          xb_q    <= '0;
          yb_q    <= COEF_BITS'(1);
          state_q <= S_EUC_LOOP;
        end
        S_EUC_LOOP: begin
          if (ea_q == '0) state_q <= S_RED_CQ;
        end
        S_EUC_UPX: begin
          xtmp_q  <= coef_new;
          state_q <= S_EUC_UPY;
        end
        S_EUC_UPY: begin
          xa_q    <= xtmp_q;
          ya_q    <= coef_new;
          xb_q    <= xa_q;
          yb_q    <= ya_q;
          eb_q    <= ea_q;
          ea_q    <= mu_acc_q[PRIME_BITS-1:0];
          state_q <= S_EUC_LOOP;
        end
        S_RED_CP: begin
          tq_q <= mu_acc_q;
        end
        S_FIN: begin
          x_q     <= x_d;
          y_q     <= y_d;
          state_q <= S_FIN2;
        end
        S_FIN2: begin
          res_q.root_one   <= x_q;
          res_q.root_two   <= neg_mod(x_q, modulus_q);
          res_q.root_three <= y_q;
          res_q.root_four  <= neg_mod(y_q, modulus_q);
          state_q          <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_q   <= res_q;
            state_q <= S_IDLE;
          end
        end
        default: ;
      endcase

      // launch: the launching states leave state_q to this step
      if (mu_go) begin
        mu_a_q    <= mu_a_in;
        mu_b_q    <= mu_b_in;
        mu_m_q    <= mu_m_in;
        mu_acc_q  <= '0;
        mu_quo_q  <= '0;
        mu_cnt_q  <= CNT_BITS'(WORD_BITS);
        mu_busy_q <= 1'b1;
        nxt_q     <= go_nxt;
        state_q   <= S_RUN;
      end
    end
  end

  // the multiplier only runs while the sequencer waits on it
  a_busy_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mu_busy_q |-> (state_q == S_RUN))
    else $error("multiplier busy outside wait state");

  // partial product stays reduced below the modulus
  a_acc_red : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mu_busy_q |-> (mu_acc_q < mu_m_q))
    else $error("multiplier accumulator not reduced");

  // encryption leaves the extra roots at zero
  a_enc_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) && (act_q == ACT_ENCRYPT) |->
      (res_q.root_two == '0) && (res_q.root_three == '0) && (res_q.root_four == '0))
    else $error("encrypt result has nonzero extra roots");

endmodule

// ===== sim/rabin_check.sv =====
// Checker: tracks the key registers, predicts each result and compares output beats.
`timescale 1ns / 100ps

module rabin_check
  import rabin_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [WORD_BITS-1:0] pwdata,
  input  logic                 pready,
  input  logic                 in_valid_i,
  input  logic                 in_stall_o,
  input  in_t                  in_data_i,
  input  logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  out_t                 out_data_o,
  output int                   fail_cnt_o,
  output int                   roots_due_o
);

  logic [PRIME_BITS-1:0] key_p;
  logic [PRIME_BITS-1:0] key_q;
  logic [WORD_BITS-1:0]  key_n;
  out_t                  roots_due[$];

  function automatic longint unsigned mod_pow(longint unsigned b, longint unsigned e,
                                              longint unsigned m);
    longint unsigned acc;
    acc = 1;
    if (m == 0) return 0;
    b = b % m;
    while (e > 0) begin
      if (e[0]) acc = (acc * b) % m;
      e = e >> 1;
      b = (b * b) % m;
    end
    return acc;
  endfunction

  // signed value folded into 0..m-1
  function automatic longint unsigned fold_mod(longint v, longint unsigned m);
    longint unsigned mag;
    if (v >= 0) return longint'(v) % m;
    mag = (64'd0 - longint'(v)) % m;
    return (mag == 0) ? 0 : m - mag;
  endfunction

  function automatic out_t rabin_roots(in_t it);
    out_t            o;
    longint unsigned n, p, q, a, b, t, r, s, tp, tq, x, y, msg;
    longint unsigned quo[128];
    longint          cx, cy, nx;
    int              cnt;
    o   = '0;
    n   = key_n;
    p   = key_p;
    q   = key_q;
    if (n == 0) return o;
    if (it.action == ACT_ENCRYPT) begin
      msg = it.value % n;
      o.root_one = WORD_BITS'((msg * msg) % n);
      return o;
    end
    r = mod_pow(it.value, (p + 1) / 4, p);
    s = mod_pow(it.value, (q + 1) / 4, q);
    // extended Euclid on (p, q): cx*p + cy*q = gcd
    a = p; b = q; cnt = 0;
    while (a != 0 && cnt < 128) begin
      t = b % a;
      quo[cnt] = b / a;
      cnt++;
      b = a;
      a = t;
    end
    cx = 0; cy = 1;
    while (cnt > 0) begin
      cnt--;
      nx = cy - longint'(quo[cnt]) * cx;
      cy = cx;
      cx = nx;
    end
    tq = ((r % n) * fold_mod(cy, n)) % n;
    tq = (tq * (q % n)) % n;
    tp = ((s % n) * fold_mod(cx, n)) % n;
    tp = (tp * (p % n)) % n;
    x = (tq + tp) % n;
    y = (tq + (n - tp)) % n;
    o.root_one   = WORD_BITS'(x);
    o.root_two   = WORD_BITS'((n - x) % n);
    o.root_three = WORD_BITS'(y);
    o.root_four  = WORD_BITS'((n - y) % n);
    return o;
  endfunction

  assign roots_due_o = roots_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      key_p      <= PRIME_P_RST;
      key_q      <= PRIME_Q_RST;
      key_n      <= MODULUS_RST;
      fail_cnt_o <= 0;
      roots_due.delete();
    end else begin
      if (in_valid_i && !in_stall_o) roots_due.push_back(rabin_roots(in_data_i));
      if (out_valid_o && !out_stall_i) begin
        if (roots_due.size() == 0) begin
          fail_cnt_o <= fail_cnt_o + 1;
          if (fail_cnt_o < 10) $display("unexpected result beat %h", out_data_o);
        end else begin
          want = roots_due.pop_front();
          if (want.root_one !== out_data_o.root_one ||
              want.root_two !== out_data_o.root_two ||
              want.root_three !== out_data_o.root_three ||
              want.root_four !== out_data_o.root_four) begin
            fail_cnt_o <= fail_cnt_o + 1;
            if (fail_cnt_o < 10)
              $display("roots mismatch: exp %h %h %h %h got %h %h %h %h",
                       want.root_one, want.root_two, want.root_three, want.root_four,
                       out_data_o.root_one, out_data_o.root_two,
                       out_data_o.root_three, out_data_o.root_four);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_BITS-1:2])
          REG_PRIME_P: key_p <= pwdata[PRIME_BITS-1:0];
          REG_PRIME_Q: key_q <= pwdata[PRIME_BITS-1:0];
          REG_MODULUS: key_n <= pwdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== sim/tb_rabin_encrypt_decrypt.sv =====
// Testbench top: clock, reset, key programming, beat stimulus and verdict.
`timescale 1ns / 100ps

module tb_rabin_encrypt_decrypt;
  import rabin_pkg::*;

  localparam int LIMIT = 4000000;  // cycles
  localparam logic [ADDR_BITS-1:0] ADDR_UNMAPPED = ADDR_BITS'(12);

  logic                 clk_i, rst_ni;
  logic                 psel, penable, pwrite, pready;
  logic [ADDR_BITS-1:0] paddr;
  logic [WORD_BITS-1:0] pwdata, prdata;
  logic                 in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  in_t                  in_data_i;
  out_t                 out_data_o;
  int                   fail_cnt, roots_due;
  int                   beats_sent;
  int                   cycles;
  bit                   quiet;     // no idling on either side while set
  logic [WORD_BITS-1:0]  cur_n;

  rabin_encrypt_decrypt dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o, .out_stall_i, .out_data_o
  );

  rabin_check chk (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o, .out_stall_i, .out_data_o,
    .fail_cnt_o(fail_cnt), .roots_due_o(roots_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL rabin_encrypt_decrypt");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off so the engine fills up
  // (output reg + holding reg) and stalls its input beat.
  initial begin
    int  hold;
    bit  held;
    hold = 0;
    held = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && beats_sent == 60) begin
        held = 1;
        hold = 12000;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 23);
      end
    end
  end

  task automatic apb_write(input logic [ADDR_BITS-1:0] addr, input logic [WORD_BITS-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Key change only with the engine drained; every beat yields a result, so a
  // short settle after the last one is enough.
  task automatic set_key(input logic [WORD_BITS-1:0] p, input logic [WORD_BITS-1:0] q,
                         input logic [WORD_BITS-1:0] n);
    wait (roots_due == 0);
    repeat (8) @(posedge clk_i);
    apb_write(ADDR_BITS'(4 * REG_PRIME_P), p);
    apb_write(ADDR_BITS'(4 * REG_PRIME_Q), q);
    apb_write(ADDR_BITS'(4 * REG_MODULUS), n);
    apb_write(ADDR_UNMAPPED, $urandom());  // unmapped slot, must be ignored
    cur_n = n;
  endtask

  // One input beat; sender idles at random first, valid stays up under stall.
  task automatic send_beat(input action_e act, input logic [WORD_BITS-1:0] val);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(99) < 23) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i  <= '{action: act, value: val};
        do @(posedge clk_i); while (in_stall_o);
        beats_sent++;
        break;
      end
    end
  endtask

  // Random beat: mostly values below n and decrypts of squares (real roots).
  task automatic rand_beat();
    logic [WORD_BITS-1:0] v;
    longint unsigned      m;
    action_e              act;
    act = action_e'($urandom_range(1));
    case ($urandom_range(2))
      0: v = $urandom();
      1: v = (cur_n == 0) ? $urandom() : $urandom() % cur_n;
      default: begin
        m = (cur_n == 0) ? 0 : $urandom() % cur_n;
        v = (cur_n == 0) ? $urandom() : WORD_BITS'((m * m) % cur_n);
        act = ACT_DECRYPT;
      end
    endcase
    send_beat(act, v);
  endtask

  task automatic idle_bus();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned primes[] = '{3, 7, 11, 19, 23, 31, 43, 47, 59, 67, 71, 79, 83, 103, 107,
                              127, 131, 139, 151, 163, 167, 179, 191, 199, 211, 223, 227,
                              239, 251, 263, 271, 283, 307, 311, 331, 347, 359, 367};
    int unsigned p, q;
    beats_sent = 0;
    quiet      = 0;
    cur_n      = 21;
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset key p=3 q=7 n=21
    send_beat(ACT_ENCRYPT, 32'h0);
    send_beat(ACT_ENCRYPT, 32'hFFFF_FFFF);  // unreduced message
    send_beat(ACT_ENCRYPT, 32'd20);
    send_beat(ACT_DECRYPT, 32'd4);
    send_beat(ACT_DECRYPT, 32'h0);
    send_beat(ACT_DECRYPT, 32'hFFFF_FFFF);  // ciphertext used unreduced
    idle_bus();
    // zero modulus: all-zero result for both actions
    set_key(32'd11, 32'd19, 32'd0);
    send_beat(ACT_ENCRYPT, 32'h1234_5678);
    send_beat(ACT_DECRYPT, 32'h8765_4321);
    idle_bus();
    // both primes zero (pow mod 0, coefficients 0/1)
    set_key(32'd0, 32'd0, 32'd77);
    send_beat(ACT_DECRYPT, 32'd25);
    send_beat(ACT_ENCRYPT, 32'd76);
    idle_bus();
    // primes below 3: zero exponent, and p == q (not coprime)
    set_key(32'd1, 32'd2, 32'd2);
    send_beat(ACT_DECRYPT, 32'd9);
    idle_bus();
    set_key(32'd7, 32'd7, 32'd49);
    send_beat(ACT_DECRYPT, 32'd2);
    idle_bus();
    // extremes: all-ones primes (upper pwdata bits dropped) and modulus
    set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(ACT_ENCRYPT, 32'hFFFF_FFFE);
    send_beat(ACT_DECRYPT, 32'hFFFF_FFFF);
    idle_bus();
    // large real-looking key near the top of the prime range
    set_key(32'd65519, 32'd65479, 32'd65519 * 32'd65479);
    send_beat(ACT_DECRYPT, 32'd123456789);
    send_beat(ACT_ENCRYPT, 32'd65519 * 32'd65479 - 1);
    idle_bus();

    // random phases: mostly proper small keys, one random bad one
    for (int ph = 0; ph < 7; ph++) begin
      p = primes[$urandom_range(primes.size() - 1)];
      do q = primes[$urandom_range(primes.size() - 1)]; while (q == p);
      if (ph == 5) set_key($urandom(), $urandom(), $urandom());
      else set_key(p, q, p * q);
      quiet = (ph == 3);  // stretch with no idling on either side
      repeat (26) rand_beat();
      idle_bus();
      quiet = 0;
    end

    // sender pause until every result is back, then a short burst
    wait (roots_due == 0);
    repeat (4) rand_beat();
    idle_bus();

    wait (roots_due == 0);
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0 && roots_due == 0) begin
      $display("PASS rabin_encrypt_decrypt");
    end else begin
      $display("FAIL rabin_encrypt_decrypt");
    end
    $finish;
  end

endmodule
